>>> sv/zaf_pkg.sv
// Shared types and constants for the Z80 accumulator flag unit.
// Used by zaf_exec and z80_accumulator_flag_unit. No other dependencies.
`timescale 1ns / 1ps

package zaf_pkg;

    // Operation codes. Codes 11 to 15 are no operation.
    localparam logic [3:0] ACT_ADD16 = 4'd0;
    localparam logic [3:0] ACT_INC   = 4'd1;
    localparam logic [3:0] ACT_DEC   = 4'd2;
    localparam logic [3:0] ACT_RLCA  = 4'd3;
    localparam logic [3:0] ACT_RRCA  = 4'd4;
    localparam logic [3:0] ACT_RLA   = 4'd5;
    localparam logic [3:0] ACT_RRA   = 4'd6;
    localparam logic [3:0] ACT_DAA   = 4'd7;
    localparam logic [3:0] ACT_CPL   = 4'd8;
    localparam logic [3:0] ACT_SCF   = 4'd9;
    localparam logic [3:0] ACT_CCF   = 4'd10;

    // Flag bit positions: S Z Y H X P N C.
    localparam int FL_S = 7;
    localparam int FL_Z = 6;
    localparam int FL_Y = 5;
    localparam int FL_H = 4;
    localparam int FL_X = 3;
    localparam int FL_P = 2;
    localparam int FL_N = 1;
    localparam int FL_C = 0;

    // DAA thresholds and correction terms.
    localparam logic [3:0] DAA_NIB_MAX  = 4'h9;
    localparam logic [3:0] DAA_NIB_LOW  = 4'h6;
    localparam logic [7:0] DAA_BYTE_MAX = 8'h99;
    localparam logic [7:0] DAA_CORR_LO  = 8'h06;
    localparam logic [7:0] DAA_CORR_HI  = 8'h60;

    // Overflow points for INC and DEC.
    localparam logic [7:0] INC_OVF_VAL = 8'h7F;
    localparam logic [7:0] DEC_OVF_VAL = 8'h80;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  operand_value;
        logic [7:0]  flags_in;
        logic [15:0] hl_value;
        logic [15:0] pair_value;
    } item_t;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_word;
        logic [7:0]  flags_out;
    } result_t;

endpackage

>>> sv/z80_accumulator_flag_unit.sv
// Top level of the Z80 accumulator flag unit: input register, execute stage, result register.
// Depends on zaf_pkg and zaf_exec.
`timescale 1ns / 1ps

// The unit takes one operation per clock cycle and never pushes back: busy is
// always low, so every cycle with start high is a transfer. Each transfer
// produces exactly one result, which passes the input register and then the
// result register and is shown on result for a single cycle with done high.
// The receiver cannot stall the unit, so it must take the result in that
// cycle; nothing is held for it. The operation itself (one 16-bit add or an
// 8-bit add, subtract, shift, complement or flag update) lies between the two registers.
// The unit holds no architectural state; only the pipeline valid bits reset.
module z80_accumulator_flag_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  zaf_pkg::item_t    item,
    output logic              done,
    output zaf_pkg::result_t  result
);
    import zaf_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   item_reg;
    logic    done_reg;
    logic    done_next;
    result_t result_reg;
    result_t exec_result;

    // Never stall the sender.
    assign busy = 1'b0;

    assign in_valid_next = start && !busy;
    assign done_next     = in_valid_reg;

    // Advance the valid bits every cycle; drop them on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            done_reg     <= done_next;
        end
    end

    // Capture the operands on a transfer; hold them otherwise.
    always_ff @(posedge clk)
    begin
        if (in_valid_next)
        begin
            item_reg <= item;
        end
    end

    zaf_exec u_exec (
        .item   (item_reg),
        .result (exec_result)
    );

    // Load the result register when a registered item is present.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= exec_result;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> sv/zaf_exec.sv
// Combinational execute stage of the Z80 accumulator flag unit.
// Depends on zaf_pkg for item_t, result_t, operation codes and flag positions.
`timescale 1ns / 1ps

module zaf_exec (
    input  zaf_pkg::item_t   item,
    output zaf_pkg::result_t result
);
    import zaf_pkg::*;

    logic [7:0]  a;
    logic [7:0]  f;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [7:0]  inc_val;
    logic [7:0]  dec_val;
    logic        n_in;
    logic        h_in;
    logic        c_in;
    logic        lo_gt9;
    logic [7:0]  corr;
    logic [7:0]  daa_val;

    assign a    = item.operand_value;
    assign n_in = item.flags_in[FL_N];
    assign h_in = item.flags_in[FL_H];
    assign c_in = item.flags_in[FL_C];

    assign sum17   = {1'b0, item.hl_value} + {1'b0, item.pair_value};
    assign sum13   = {1'b0, item.hl_value[11:0]} + {1'b0, item.pair_value[11:0]};
    assign inc_val = a + 8'd1;
    assign dec_val = a - 8'd1;

    // DAA correction
    assign lo_gt9  = a[3:0] > DAA_NIB_MAX;
    assign corr    = ((h_in || (!n_in && lo_gt9)) ? DAA_CORR_LO : 8'h00)
                   | ((c_in || (!n_in && (a > DAA_BYTE_MAX))) ? DAA_CORR_HI : 8'h00);
    assign daa_val = n_in ? (a - corr) : (a + corr);

    always_comb
    begin
        result.result_byte = a;
        result.result_word = 16'h0000;
        f                  = item.flags_in;
        case (item.action)
            ACT_ADD16:
            begin
                result.result_byte = 8'h00;
                result.result_word = sum17[15:0];
                f[FL_H] = sum13[12];
                f[FL_N] = 1'b0;
                f[FL_C] = sum17[16];
                f[FL_Y] = sum17[13];
                f[FL_X] = sum17[11];
            end
            ACT_INC:
            begin
                result.result_byte = inc_val;
                f[FL_S] = inc_val[7];
                f[FL_Z] = (inc_val == 8'h00);
                f[FL_H] = (a[3:0] == 4'hF);
                f[FL_P] = (a == INC_OVF_VAL);
                f[FL_N] = 1'b0;
                f[FL_Y] = inc_val[5];
                f[FL_X] = inc_val[3];
            end
            ACT_DEC:
            begin
                result.result_byte = dec_val;
                f[FL_S] = dec_val[7];
                f[FL_Z] = (dec_val == 8'h00);
                f[FL_H] = (a[3:0] == 4'h0);
                f[FL_P] = (a == DEC_OVF_VAL);
                f[FL_N] = 1'b1;
                f[FL_Y] = dec_val[5];
                f[FL_X] = dec_val[3];
            end
            ACT_RLCA:
            begin
                result.result_byte = {a[6:0], a[7]};
                f[FL_H] = 1'b0;
                f[FL_N] = 1'b0;
                f[FL_C] = a[7];
                f[FL_Y] = a[4];
                f[FL_X] = a[2];
            end
            ACT_RRCA:
            begin
                result.result_byte = {a[0], a[7:1]};
                f[FL_H] = 1'b0;
                f[FL_N] = 1'b0;
                f[FL_C] = a[0];
                f[FL_Y] = a[6];
                f[FL_X] = a[4];
            end
            ACT_RLA:
            begin
                result.result_byte = {a[6:0], c_in};
                f[FL_H] = 1'b0;
                f[FL_N] = 1'b0;
                f[FL_C] = a[7];
                f[FL_Y] = a[4];
                f[FL_X] = a[2];
            end
            ACT_RRA:
            begin
                result.result_byte = {c_in, a[7:1]};
                f[FL_H] = 1'b0;
                f[FL_N] = 1'b0;
                f[FL_C] = a[0];
                f[FL_Y] = a[6];
                f[FL_X] = a[4];
            end
            ACT_DAA:
            begin
                result.result_byte = daa_val;
                f[FL_S] = daa_val[7];
                f[FL_Z] = (daa_val == 8'h00);
                f[FL_P] = ~^daa_val;
                f[FL_H] = n_in ? (h_in && (a[3:0] < DAA_NIB_LOW)) : lo_gt9;
                f[FL_C] = c_in || (!n_in && (a > DAA_BYTE_MAX));
                f[FL_Y] = daa_val[5];
                f[FL_X] = daa_val[3];
            end
            ACT_CPL:
            begin
                result.result_byte = ~a;
                f[FL_H] = 1'b1;
                f[FL_N] = 1'b1;
                f[FL_Y] = ~a[5];
                f[FL_X] = ~a[3];
            end
            ACT_SCF:
            begin
                f[FL_H] = 1'b0;
                f[FL_N] = 1'b0;
                f[FL_C] = 1'b1;
            end
            ACT_CCF:
            begin
                f[FL_H] = c_in;
                f[FL_N] = 1'b0;
                f[FL_C] = ~c_in;
            end
            default:
            begin
                f = item.flags_in;
            end
        endcase
        result.flags_out = f;
    end

endmodule
